@@ hw/rtl/pbpc_pkg.sv @@
`timescale 1ns / 1ps

package pbpc_pkg;

  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned DUTY_W    = 14;
  localparam int unsigned RES_W     = 28;
  localparam int unsigned CFG_W     = 28;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PULSE_W   = 10;
  localparam int unsigned BITS_W    = 5;
  localparam int unsigned DIV_W     = 30;
  localparam int unsigned DVSR_W    = 24;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned PUL_Q_W   = 20;

  // Divide by 10000 as a shift by 4 and a multiply by 2**36 / 625, rounded up
  localparam int unsigned SCALE_SH  = 4;
  localparam int unsigned RECIP_SH  = 36;
  localparam int unsigned RECIP_W   = 27;
  localparam int unsigned PROD_W    = DIV_W - SCALE_SH + RECIP_W;
  localparam int unsigned CMP_Q_W   = PROD_W - RECIP_SH;

  localparam logic [DIV_CNT_W-1:0] PER_STEPS = DIV_CNT_W'(RES_W);
  localparam logic [DIV_CNT_W-1:0] PUL_STEPS = DIV_CNT_W'(PUL_Q_W);

  localparam logic [RES_W-1:0]    PERIOD_MIN = RES_W'(2);
  localparam logic [RES_W-1:0]    PERIOD_MAX = RES_W'(65535);
  localparam logic [DUTY_W-1:0]   DUTY_FULL  = DUTY_W'(10000);
  localparam logic [DIV_W-1:0]    ROUND_HALF = DIV_W'(5000);
  localparam logic [RECIP_W-1:0]  DUTY_RECIP = RECIP_W'(109951163);
  localparam logic [PUL_Q_W-1:0]  PULSE_NUM  = PUL_Q_W'(1000000);
  localparam logic [PUL_Q_W-1:0]  PULSE_ADD  = PUL_Q_W'(2);
  localparam logic [PUL_Q_W-1:0]  PULSE_LO   = PUL_Q_W'(200);
  localparam logic [PUL_Q_W-1:0]  PULSE_HI   = PUL_Q_W'(1000);
  localparam logic [BITS_W-1:0]   BITS_SAT   = BITS_W'(16);

  localparam logic [FREQ_W-1:0] RST_MIN_FREQ = FREQ_W'(10);
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ = FREQ_W'(1000000);
  localparam logic [RES_W-1:0]  RST_HI_RES   = RES_W'(10000000);
  localparam logic [FREQ_W-1:0] RST_HI_FLOOR = FREQ_W'(153);
  localparam logic [RES_W-1:0]  RST_LO_RES   = RES_W'(625000);
  localparam logic [FREQ_W-1:0] RST_LO_FLOOR = FREQ_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FREQ = 3'd0,
    CFG_MAX_FREQ = 3'd1,
    CFG_HI_RES   = 3'd2,
    CFG_HI_FLOOR = 3'd3,
    CFG_LO_RES   = 3'd4,
    CFG_LO_FLOOR = 3'd5
  } pbpc_cfg_idx_e;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [RES_W-1:0]  hi_res;
    logic [FREQ_W-1:0] hi_floor;
    logic [RES_W-1:0]  lo_res;
    logic [FREQ_W-1:0] lo_floor;
  } pbpc_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DVSR_W-1:0]    divisor;
    logic [DIV_CNT_W-1:0] steps;
  } pbpc_div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PER_START,
    ST_PER_WAIT,
    ST_CHECK,
    ST_CMP_MUL,
    ST_CMP_SEL,
    ST_PUL_START,
    ST_PUL_WAIT,
    ST_OUT
  } pbpc_state_e;

  function automatic logic [BITS_W-1:0] pbpc_log2_16(input logic [PERIOD_W-1:0] v);
    logic [BITS_W-1:0] r;
    r = '0;
    for (int i = 1; i < PERIOD_W; i++) begin
      if (v[i]) begin
        r = BITS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pbpc_cfg_regs.sv @@
`timescale 1ns / 1ps

module pbpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  output pbpc_pkg::pbpc_cfg_t           cfg_o
);
  import pbpc_pkg::*;

  pbpc_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pbpc_cfg_idx_e'(cfg_idx_i))
        CFG_MIN_FREQ: cfg_d.min_freq = cfg_wdata_i[FREQ_W-1:0];
        CFG_MAX_FREQ: cfg_d.max_freq = cfg_wdata_i[FREQ_W-1:0];
        CFG_HI_RES:   cfg_d.hi_res   = cfg_wdata_i[RES_W-1:0];
        CFG_HI_FLOOR: cfg_d.hi_floor = cfg_wdata_i[FREQ_W-1:0];
        CFG_LO_RES:   cfg_d.lo_res   = cfg_wdata_i[RES_W-1:0];
        CFG_LO_FLOOR: cfg_d.lo_floor = cfg_wdata_i[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_freq <= RST_MIN_FREQ;
      cfg_q.max_freq <= RST_MAX_FREQ;
      cfg_q.hi_res   <= RST_HI_RES;
      cfg_q.hi_floor <= RST_HI_FLOOR;
      cfg_q.lo_res   <= RST_LO_RES;
      cfg_q.lo_floor <= RST_LO_FLOOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/pbpc_div.sv @@
`timescale 1ns / 1ps

module pbpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbpc_pkg::pbpc_div_req_t     req_i,
  output logic                        done_o,
  output logic [pbpc_pkg::DIV_W-1:0]  quot_o
);
  import pbpc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_d, cnt_q;
  logic                 done_d, done_q;
  logic [DIV_W-1:0]     quo_d, quo_q;
  logic [DVSR_W-1:0]    rem_d, rem_q;
  logic [DVSR_W-1:0]    dvsr_d, dvsr_q;
  logic [DVSR_W:0]      trial;
  logic [DVSR_W:0]      diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvsr_q};
  assign diff  = trial - {1'b0, dvsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (req_i.start) begin
      cnt_d  = req_i.steps;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvsr_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
      quo_d  = {quo_q[DIV_W-2:0], ge};
      rem_d  = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> cnt_q == '0)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still counting");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("divider step count skipped");
`endif

endmodule

@@ hw/rtl/pwm_band_period_compare_calc.sv @@
`timescale 1ns / 1ps
// Accepted items pass period division, check, compare multiply and select, pulse
// division and output; items rejected after period division go from check to output.
// New items are stalled until the last is output; one bit-per-cycle divider is shared
// by the period (28 steps) and pulse (20 steps) divisions; compare uses a multiply.
// Reset: asynchronous active low; config, state and stored band (high) to defaults.
module pwm_band_period_compare_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbpc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pbpc_pkg::FREQ_W-1:0]       freq_i,
  input  logic [pbpc_pkg::DUTY_W-1:0]       duty_centi_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic                              band_o,
  output logic                              band_changed_o,
  output logic [pbpc_pkg::PERIOD_W-1:0]     period_ticks_o,
  output logic [pbpc_pkg::PERIOD_W-1:0]     compare_ticks_o,
  output logic [pbpc_pkg::PULSE_W-1:0]      pulse_us_o,
  output logic [pbpc_pkg::BITS_W-1:0]       duty_bits_o
);
  import pbpc_pkg::*;

  pbpc_cfg_t     cfg;
  pbpc_div_req_t div_req;
  logic          div_done;
  logic [DIV_W-1:0] div_quot;

  pbpc_state_e state_d, state_q;

  logic [FREQ_W-1:0]   freq_d, freq_q;
  logic [DUTY_W-1:0]   duty_d, duty_q;
  logic                band_d, band_q;
  logic                none_d, none_q;
  logic [RES_W-1:0]    per_d, per_q;
  logic                ok_d, ok_q;
  logic [BITS_W-1:0]   bits_d, bits_q;
  logic [DIV_W-1:0]    num_d, num_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic [PERIOD_W-1:0] cmp_d, cmp_q;
  logic [PULSE_W-1:0]  pul_d, pul_q;

  logic                out_valid_d, out_valid_q;
  logic                cur_band_d, cur_band_q;
  logic                status_q, obnd_q, ochg_q;
  logic [PERIOD_W-1:0] oper_q, ocmp_q;
  logic [PULSE_W-1:0]  opul_q;
  logic [BITS_W-1:0]   obits_q;

  logic                out_load;
  logic                hi_sel;
  logic [PUL_Q_W-1:0]  pul_sum;
  logic [CMP_Q_W-1:0]  cmp_quo;

  pbpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pbpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign hi_sel     = freq_q >= cfg.hi_floor;
  assign pul_sum    = div_quot[PUL_Q_W-1:0] + PULSE_ADD;
  assign cmp_quo    = prod_q[PROD_W-1:RECIP_SH];

  always_comb begin
    state_d = state_q;
    freq_d  = freq_q;
    duty_d  = duty_q;
    band_d  = band_q;
    none_d  = none_q;
    per_d   = per_q;
    ok_d    = ok_q;
    bits_d  = bits_q;
    num_d   = num_q;
    prod_d  = prod_q;
    cmp_d   = cmp_q;
    pul_d   = pul_q;
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          freq_d  = freq_i;
          duty_d  = duty_centi_i;
          state_d = ST_PER_START;
        end
      end
      ST_PER_START: begin
        band_d           = !hi_sel;
        none_d           = !hi_sel && (freq_q < cfg.lo_floor);
        div_req.start    = 1'b1;
        div_req.dividend = {(hi_sel ? cfg.hi_res : cfg.lo_res), 2'b00};
        div_req.divisor  = freq_q;
        div_req.steps    = PER_STEPS;
        state_d          = ST_PER_WAIT;
      end
      ST_PER_WAIT: begin
        if (div_done) begin
          per_d   = (freq_q == '0) ? '0 : div_quot[RES_W-1:0];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ok_d = (freq_q >= cfg.min_freq) && (freq_q <= cfg.max_freq) &&
               (duty_q <= DUTY_FULL) && !none_q &&
               (per_q >= PERIOD_MIN) && (per_q <= PERIOD_MAX);
        if (none_q || per_q < PERIOD_MIN) begin
          bits_d = '0;
        end else if (per_q > PERIOD_MAX) begin
          bits_d = BITS_SAT;
        end else begin
          bits_d = pbpc_log2_16(per_q[PERIOD_W-1:0]);
        end
        num_d   = DIV_W'(duty_q) * DIV_W'(per_q[PERIOD_W-1:0]) + ROUND_HALF;
        state_d = ok_d ? ST_CMP_MUL : ST_OUT;
      end
      ST_CMP_MUL: begin
        prod_d  = PROD_W'(num_q[DIV_W-1:SCALE_SH]) * PROD_W'(DUTY_RECIP);
        state_d = ST_CMP_SEL;
      end
      ST_CMP_SEL: begin
        cmp_d   = (cmp_quo > CMP_Q_W'(per_q[PERIOD_W-1:0])) ? per_q[PERIOD_W-1:0]
                                                          : cmp_quo[PERIOD_W-1:0];
        state_d = ST_PUL_START;
      end
      ST_PUL_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {PULSE_NUM, (DIV_W - PUL_Q_W)'(0)};
        div_req.divisor  = freq_q;
        div_req.steps    = PUL_STEPS;
        state_d          = ST_PUL_WAIT;
      end
      ST_PUL_WAIT: begin
        if (div_done) begin
          if (pul_sum > PULSE_HI) begin
            pul_d = PULSE_HI[PULSE_W-1:0];
          end else if (pul_sum < PULSE_LO) begin
            pul_d = PULSE_LO[PULSE_W-1:0];
          end else begin
            pul_d = pul_sum[PULSE_W-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    cur_band_d  = cur_band_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      if (ok_q) begin
        cur_band_d = band_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_band_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_band_q  <= cur_band_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    duty_q <= duty_d;
    band_q <= band_d;
    none_q <= none_d;
    per_q  <= per_d;
    ok_q   <= ok_d;
    bits_q <= bits_d;
    num_q  <= num_d;
    prod_q <= prod_d;
    cmp_q  <= cmp_d;
    pul_q  <= pul_d;
    if (out_load) begin
      status_q <= !ok_q;
      obnd_q   <= ok_q && band_q;
      ochg_q   <= ok_q && (band_q != cur_band_q);
      oper_q   <= ok_q ? per_q[PERIOD_W-1:0] : '0;
      ocmp_q   <= ok_q ? cmp_q : '0;
      opul_q   <= ok_q ? pul_q : '0;
      obits_q  <= bits_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign band_o          = obnd_q;
  assign band_changed_o  = ochg_q;
  assign period_ticks_o  = oper_q;
  assign compare_ticks_o = ocmp_q;
  assign pulse_us_o      = opul_q;
  assign duty_bits_o     = obits_q;

`ifndef ASSERT_OFF
  a_ok_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> period_ticks_o >= PERIOD_W'(2) &&
                                 compare_ticks_o <= period_ticks_o)
    else $error("accepted item with bad period or compare");
  a_ok_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> pulse_us_o >= PULSE_LO[PULSE_W-1:0] &&
                                 pulse_us_o <= PULSE_HI[PULSE_W-1:0])
    else $error("pulse length out of range");
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> period_ticks_o == '0 && pulse_us_o == '0 &&
                                !band_changed_o)
    else $error("rejected item carries data");
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_PER_WAIT || state_q == ST_PUL_WAIT)
    else $error("divider result with no consumer");
`endif

endmodule
